### sv/gcm_ghash_pkg.sv
// ----------------------------------------------------------------------------
// gcm_ghash_pkg
// Shared types and constants of the GCM GHASH tag engine: transaction
// payload structs, operation codes and configuration register indexes.
// ----------------------------------------------------------------------------
package gcm_ghash_pkg;

   // block geometry
   localparam int BLOCK_W      = 128;
   localparam int HALF_W       = 64;
   localparam int BLOCK_BYTES  = 16;
   localparam int BYTE_CNT_W   = 61;

   // operation codes
   localparam logic [1:0] OP_AAD    = 2'd0;
   localparam logic [1:0] OP_CIPHER = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   // configuration register indexes
   localparam logic CSR_HASH_KEY_HI = 1'b0;
   localparam logic CSR_HASH_KEY_LO = 1'b1;

   // reduction polynomial, GCM bit order (top byte 0xe1)
   localparam logic [BLOCK_W-1:0] GF_REDUCE = {8'he1, 120'd0};

   // full block byte count
   localparam logic [4:0] FULL_BLOCK_CNT = 5'd16;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] block_hi;
      logic [63:0] block_lo;
      logic [4:0]  byte_count;
      logic [63:0] mask_hi;
      logic [63:0] mask_lo;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] tag_hi;
      logic [63:0] tag_lo;
   } rsp_payload_type;

endpackage

### sv/gcm_ghash_tag_engine_unit.sv
// ----------------------------------------------------------------------------
// gcm_ghash_tag_engine_unit
// GCM GHASH engine: absorbs AAD and ciphertext blocks into a running hash
// and emits the authentication tag on a finish transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries one block per transaction: op selects
//   AAD absorb, ciphertext absorb or finish. Bytes past byte_count are
//   zeroed; an absorb with a count of zero or an unused op is accepted and dropped.
//   Counts above sixteen act as sixteen.
//   rsp channel (valid/ready) carries the tag, one per finish transaction.
//   csr port writes the hash key halves at any cycle while the block is idle.
// Throughput and datapath:
//   one transaction per cycle while no finish is held behind a waiting tag;
//   a finish passes the input stage register and then the output register
//   before rsp_valid rises. The hash update (one combinational GF(2^128)
//   multiply against the running hash register) completes combinationally, so
//   back-to-back blocks of the same message need no bubble.
// Reset:
//   clears the running hash, byte counters, hash key and both valid flags.
// Stall:
//   while a tag waits on rsp_ready, absorb transactions keep flowing; a
//   second finish waits in the input stage and req_ready drops behind it.
// ----------------------------------------------------------------------------
module gcm_ghash_tag_engine_unit (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  gcm_ghash_pkg::req_payload_type req_payload,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output gcm_ghash_pkg::rsp_payload_type rsp_payload,
   // configuration
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [63:0]                    csr_wdata
);
   import gcm_ghash_pkg::*;

   // configuration registers
   logic [HALF_W-1:0]     key_hi_ff, key_hi_in;
   logic [HALF_W-1:0]     key_lo_ff, key_lo_in;

   // message state
   logic [BLOCK_W-1:0]    hash_ff, hash_in;
   logic [BYTE_CNT_W-1:0] aad_ff, aad_in;
   logic [BYTE_CNT_W-1:0] cip_ff, cip_in;

   // input stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [1:0]            s1_op_ff;
   logic [BLOCK_W-1:0]    s1_blk_ff;
   logic [4:0]            s1_cnt_ff;
   logic [BLOCK_W-1:0]    s1_mask_ff;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                  req_take;
   logic                  req_useful;
   logic [4:0]            cnt_sat;
   logic [BLOCK_W-1:0]    blk_masked;
   logic                  s1_finish;
   logic                  s1_go;
   logic [BLOCK_W-1:0]    mul_x;
   logic [BLOCK_W-1:0]    mul_z;

   // input side: zero the bytes past the count
   always_comb begin
      cnt_sat = (req_payload.byte_count > FULL_BLOCK_CNT) ? FULL_BLOCK_CNT
                                                          : req_payload.byte_count;
      blk_masked = {req_payload.block_hi, req_payload.block_lo};
      for (int j = 0; j < BLOCK_BYTES; j++) begin
         if (5'(j) >= cnt_sat) begin
            blk_masked[BLOCK_W-1-8*j -: 8] = 8'd0;
         end
      end
   end

   // only absorbs with bytes and finishes enter the stage
   assign req_useful = (req_payload.op == OP_FINISH) ||
                       (((req_payload.op == OP_AAD) || (req_payload.op == OP_CIPHER)) &&
                        (cnt_sat != 5'd0));

   // a finish holds while the previous tag is still waiting
   assign s1_finish = (s1_op_ff == OP_FINISH);
   assign s1_go     = !(s1_finish && rsp_valid_ff && !rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in = req_take ? req_useful : (s1_valid_ff && !s1_go);

   // multiplier operand: data block or length block
   assign mul_x = hash_ff ^ (s1_finish ? {aad_ff, 3'b000, cip_ff, 3'b000} : s1_blk_ff);

   gcm_ghash_gfmul u_gfmul (
      .x (mul_x),
      .h ({key_hi_ff, key_lo_ff}),
      .z (mul_z)
   );

   // state update
   always_comb begin
      hash_in = hash_ff;
      aad_in  = aad_ff;
      cip_in  = cip_ff;
      if (s1_valid_ff && s1_go) begin
         case (s1_op_ff)
            OP_AAD: begin
               hash_in = mul_z;
               aad_in  = aad_ff + BYTE_CNT_W'(s1_cnt_ff);
            end
            OP_CIPHER: begin
               hash_in = mul_z;
               cip_in  = cip_ff + BYTE_CNT_W'(s1_cnt_ff);
            end
            OP_FINISH: begin
               hash_in = '0;
               aad_in  = '0;
               cip_in  = '0;
            end
            default: begin
               hash_in = hash_ff;
            end
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = (s1_valid_ff && s1_finish && s1_go) || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = rsp_data_ff;
      if (s1_valid_ff && s1_finish && s1_go) begin
         {rsp_data_in.tag_hi, rsp_data_in.tag_lo} = mul_z ^ s1_mask_ff;
      end
   end

   // configuration writes
   always_comb begin
      key_hi_in = key_hi_ff;
      key_lo_in = key_lo_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HASH_KEY_HI: key_hi_in = csr_wdata;
            CSR_HASH_KEY_LO: key_lo_in = csr_wdata;
            default:         key_hi_in = key_hi_ff;
         endcase
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hash_ff      <= '0;
         aad_ff       <= '0;
         cip_ff       <= '0;
         key_hi_ff    <= '0;
         key_lo_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hash_ff      <= hash_in;
         aad_ff       <= aad_in;
         cip_ff       <= cip_in;
         key_hi_ff    <= key_hi_in;
         key_lo_ff    <= key_lo_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_payload.op;
         s1_blk_ff  <= blk_masked;
         s1_cnt_ff  <= cnt_sat;
         s1_mask_ff <= {req_payload.mask_hi, req_payload.mask_lo};
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

### sv/gcm_ghash_gfmul.sv
// ----------------------------------------------------------------------------
// gcm_ghash_gfmul
// Combinational GF(2^128) multiplier in GCM bit order: z = x * h, where bit
// 127 of each operand is the first bit of the block.
// ----------------------------------------------------------------------------
module gcm_ghash_gfmul (
   input  logic [gcm_ghash_pkg::BLOCK_W-1:0] x,
   input  logic [gcm_ghash_pkg::BLOCK_W-1:0] h,
   output logic [gcm_ghash_pkg::BLOCK_W-1:0] z
);
   import gcm_ghash_pkg::*;

   logic [BLOCK_W-1:0] v;
   logic [BLOCK_W-1:0] acc;

   // shift-and-add over the key powers; v is a linear function of h only
   always_comb begin
      v   = h;
      acc = '0;
      for (int i = 0; i < BLOCK_W; i++) begin
         if (x[BLOCK_W-1-i]) begin
            acc = acc ^ v;
         end
         if (v[0]) begin
            v = {1'b0, v[BLOCK_W-1:1]} ^ GF_REDUCE;
         end else begin
            v = {1'b0, v[BLOCK_W-1:1]};
         end
      end
      z = acc;
   end

endmodule

### sv/gcm_ghash_checker.sv
// ----------------------------------------------------------------------------
// gcm_ghash_checker
// Port-level checks of the GHASH tag engine, bound to the top level.
// ----------------------------------------------------------------------------
module gcm_ghash_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input gcm_ghash_pkg::req_payload_type req_payload,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input gcm_ghash_pkg::rsp_payload_type rsp_payload
);
   import gcm_ghash_pkg::*;

   // a waiting tag holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("tag changed or dropped while stalled");

   // reset empties the output
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("tag valid after reset");

   // with no tag pending the engine always takes a transaction
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // every fresh tag comes from a finish accepted through the input stage
   // or from a finish that was held in the input stage
   a_tag_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid && !rsp_ready) |->
         $past(req_valid && req_ready && (req_payload.op == OP_FINISH), 2) ||
         $past(!req_ready, 2))
      else $error("tag without a finish transaction");

endmodule

bind gcm_ghash_tag_engine_unit gcm_ghash_checker u_gcm_ghash_checker (.*);
